// ----- rtl/prs_pkg.sv -----
// shared constants, types and helpers of the periodic report scheduler
package prs_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int N_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_MODIFY = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  localparam logic KIND_DUE = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  header;
    logic [15:0] offset;
    logic [7:0]  length;
    logic [15:0] counter;
  } entry_t;

  // slot number as reported: low three bits of the index
  function automatic logic [2:0] slot_code(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+2:0] wide;
    wide = {3'b000, idx};
    return wide[2:0];
  endfunction

endpackage

// ----- rtl/prs_ram.sv -----
// generic single write port, single read port ram with registered read
module prs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/periodic_report_scheduler_core.sv -----
// periodic report scheduler core: job table walk for tick and modify commands
// tick and modify keep busy high from the accepting edge through the scan and finish states;
// the next transaction can be taken once busy has fallen
// the walk issues one table ram read per slot per cycle; the registered ram read, the empty
// cycle that closes the walk and the finishing step follow the reads
// due reports leave in the cycle after the next due slot is found, the last one (and the ack)
// in the first cycle after busy falls; stop and unused commands never raise busy
// synchronous active-low reset disables all slots and returns to idle; the ram is not cleared
module periodic_report_scheduler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_job_header,
  input  logic [15:0] in_job_offset,
  input  logic [7:0]  in_job_length,
  input  logic [15:0] in_job_period,
  output logic        out_valid,
  output logic        out_kind,
  output logic        out_success,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_due_header,
  output logic [15:0] out_due_offset,
  output logic [7:0]  out_due_length,
  output logic        out_last
);

  // state machine
  prs_pkg::state_t state_r, state_nxt;

  // captured command transaction
  logic [1:0]  cmd_r;
  logic [7:0]  hdr_r;
  logic [15:0] off_r;
  logic [7:0]  len_r;
  logic [15:0] per_r;

  // slot enables live in flops so stop and reset clear them at once
  logic [prs_pkg::SLOTS-1:0] enable_r, enable_nxt;

  // walk control
  logic [prs_pkg::CNT_W-1:0]  issue_r, issue_nxt;
  logic                       proc_vld_r;
  logic [prs_pkg::SLOT_W-1:0] proc_idx_r;
  logic                       issue_done;
  logic                       scan_end;

  // modify match tracking
  logic                       found_r, found_nxt;
  logic [prs_pkg::SLOT_W-1:0] found_idx_r;

  // due reports: one held back so the final one can carry last
  logic [prs_pkg::N_W-1:0] dues_r, dues_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [2:0]              pend_slot_r;
  logic [7:0]              pend_hdr_r;
  logic [15:0]             pend_off_r;
  logic [7:0]              pend_len_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic        out_success_r, out_success_nxt;
  logic [2:0]  out_slot_r, out_slot_nxt;
  logic [7:0]  out_hdr_r, out_hdr_nxt;
  logic [15:0] out_off_r, out_off_nxt;
  logic [7:0]  out_len_r, out_len_nxt;
  logic        out_last_r, out_last_nxt;

  // table ram ports
  logic                       rd_en;
  logic [prs_pkg::SLOT_W-1:0] rd_addr;
  prs_pkg::entry_t            rd_data;
  logic                       wr_en;
  logic [prs_pkg::SLOT_W-1:0] wr_addr;
  prs_pkg::entry_t            wr_data;

  // per-slot evaluation of the entry coming out of the ram
  logic                       accept;
  logic                       is_tick;
  logic                       en_p;
  logic [15:0]                cnt_inc;
  logic                       due_hit;
  logic                       tick_wr;
  logic                       match_hit;
  logic                       free_any;
  logic [prs_pkg::SLOT_W-1:0] free_idx;
  logic                       add_ok;

  assign busy   = (state_r != prs_pkg::ST_IDLE);
  assign accept = start && !busy;

  prs_ram #(
    .WIDTH($bits(prs_pkg::entry_t)),
    .DEPTH(prs_pkg::SLOTS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // walk: one read issued per cycle, entry evaluated the cycle after
  assign issue_done = (issue_r == prs_pkg::CNT_W'(prs_pkg::SLOTS));
  assign scan_end   = issue_done && !proc_vld_r;
  assign rd_en      = (state_r == prs_pkg::ST_SCAN) && !issue_done;
  assign rd_addr    = issue_r[prs_pkg::SLOT_W-1:0];

  assign is_tick = (cmd_r == prs_pkg::CMD_TICK);
  assign en_p    = enable_r[proc_idx_r];
  // counter saturates at its maximum
  assign cnt_inc = (&rd_data.counter) ? rd_data.counter : rd_data.counter + 16'd1;

  assign tick_wr = proc_vld_r && is_tick && en_p;
  assign due_hit = tick_wr && (cnt_inc >= rd_data.period) &&
                   (dues_r < prs_pkg::N_W'(prs_pkg::MAX_RESULTS));

  // only the first enabled match counts
  assign match_hit = proc_vld_r && !is_tick && en_p && !found_r &&
                     (rd_data.header == hdr_r) && (rd_data.offset == off_r) &&
                     (rd_data.length == len_r);

  // lowest disabled slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = prs_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!enable_r[i]) begin
        free_any = 1'b1;
        free_idx = prs_pkg::SLOT_W'(i);
      end
    end
  end

  assign add_ok = (state_r == prs_pkg::ST_FINISH) && (cmd_r == prs_pkg::CMD_MODIFY) &&
                  !found_r && (per_r != 16'd0) && free_any;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prs_pkg::ST_IDLE: begin
        if (accept && ((in_command == prs_pkg::CMD_TICK) ||
                       (in_command == prs_pkg::CMD_MODIFY))) begin
          state_nxt = prs_pkg::ST_SCAN;
        end
      end
      prs_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = prs_pkg::ST_FINISH;
        end
      end
      prs_pkg::ST_FINISH: begin
        state_nxt = prs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = prs_pkg::ST_IDLE;
      end
    endcase
  end

  // table write back: tick counter update, period update on match, or new job
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_r;
    wr_data = rd_data;
    priority if (tick_wr) begin
      wr_en           = 1'b1;
      wr_data.counter = due_hit ? 16'd0 : cnt_inc;
    end else if (match_hit && (per_r != 16'd0)) begin
      wr_en          = 1'b1;
      wr_data.period = per_r;
    end else if (add_ok) begin
      wr_en           = 1'b1;
      wr_addr         = free_idx;
      wr_data.period  = per_r;
      wr_data.header  = hdr_r;
      wr_data.offset  = off_r;
      wr_data.length  = len_r;
      wr_data.counter = 16'd0;
    end else begin
      wr_en = 1'b0;
    end
  end

  // walk, enable, match and pending-report bookkeeping
  always_comb begin
    issue_nxt    = issue_r;
    enable_nxt   = enable_r;
    found_nxt    = found_r;
    dues_nxt     = dues_r;
    pend_vld_nxt = pend_vld_r;
    if (accept) begin
      issue_nxt    = '0;
      found_nxt    = 1'b0;
      dues_nxt     = '0;
      pend_vld_nxt = 1'b0;
      if (in_command == prs_pkg::CMD_STOP) begin
        enable_nxt = '0;
      end
    end
    if (rd_en) begin
      issue_nxt = issue_r + prs_pkg::CNT_W'(1);
    end
    if (match_hit) begin
      found_nxt = 1'b1;
      if (per_r == 16'd0) begin
        enable_nxt[proc_idx_r] = 1'b0;
      end
    end
    if (add_ok) begin
      enable_nxt[free_idx] = 1'b1;
    end
    if (due_hit) begin
      dues_nxt     = dues_r + prs_pkg::N_W'(1);
      pend_vld_nxt = 1'b1;
    end
  end

  // result outputs
  always_comb begin
    out_valid_nxt   = 1'b0;
    out_kind_nxt    = prs_pkg::KIND_DUE;
    out_success_nxt = 1'b0;
    out_slot_nxt    = 3'd0;
    out_hdr_nxt     = 8'd0;
    out_off_nxt     = 16'd0;
    out_len_nxt     = 8'd0;
    out_last_nxt    = 1'b0;
    if ((state_r == prs_pkg::ST_SCAN) && due_hit && pend_vld_r) begin
      // a later due slot exists, so the held one is not the last
      out_valid_nxt = 1'b1;
      out_slot_nxt  = pend_slot_r;
      out_hdr_nxt   = pend_hdr_r;
      out_off_nxt   = pend_off_r;
      out_len_nxt   = pend_len_r;
    end else if (state_r == prs_pkg::ST_FINISH) begin
      if (is_tick) begin
        out_valid_nxt = pend_vld_r;
        out_slot_nxt  = pend_slot_r;
        out_hdr_nxt   = pend_hdr_r;
        out_off_nxt   = pend_off_r;
        out_len_nxt   = pend_len_r;
        out_last_nxt  = 1'b1;
      end else begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = prs_pkg::KIND_ACK;
        out_success_nxt = found_r || add_ok;
        out_last_nxt    = 1'b1;
        if (found_r) begin
          out_slot_nxt = prs_pkg::slot_code(found_idx_r);
        end else if (add_ok) begin
          out_slot_nxt = prs_pkg::slot_code(free_idx);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prs_pkg::ST_IDLE;
      enable_r    <= '0;
      issue_r     <= '0;
      proc_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      dues_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      issue_r     <= issue_nxt;
      proc_vld_r  <= rd_en;
      found_r     <= found_nxt;
      dues_r      <= dues_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      hdr_r <= in_job_header;
      off_r <= in_job_offset;
      len_r <= in_job_length;
      per_r <= in_job_period;
    end
    proc_idx_r <= rd_addr;
    if (match_hit) begin
      found_idx_r <= proc_idx_r;
    end
    if (due_hit) begin
      pend_slot_r <= prs_pkg::slot_code(proc_idx_r);
      pend_hdr_r  <= rd_data.header;
      pend_off_r  <= rd_data.offset;
      pend_len_r  <= rd_data.length;
    end
    out_kind_r    <= out_kind_nxt;
    out_success_r <= out_success_nxt;
    out_slot_r    <= out_slot_nxt;
    out_hdr_r     <= out_hdr_nxt;
    out_off_r     <= out_off_nxt;
    out_len_r     <= out_len_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_success    = out_success_r;
  assign out_slot       = out_slot_r;
  assign out_due_header = out_hdr_r;
  assign out_due_offset = out_off_r;
  assign out_due_length = out_len_r;
  assign out_last       = out_last_r;

  // an acknowledgement is always the only result of its transaction
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == prs_pkg::KIND_ACK) |-> out_last)
    else $error("modify acknowledgement without last");

  // the table is never written while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prs_pkg::ST_IDLE) |-> !wr_en)
    else $error("table write while idle");

  // due count stays within the result limit
  a_due_cap: assert property (@(posedge clk) disable iff (!rst_n)
    dues_r <= prs_pkg::N_W'(prs_pkg::MAX_RESULTS))
    else $error("due count above limit");

  // an accepted tick starts the walk in the next cycle
  a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == prs_pkg::CMD_TICK) |=> state_r == prs_pkg::ST_SCAN)
    else $error("tick did not start the table walk");

endmodule

// ----- dv/prs_tb_pkg.sv -----
// job table tracker class and transaction types for the report scheduler testbench
package prs_tb_pkg;
  import prs_pkg::*;

  typedef struct packed {
    logic        en;
    logic [15:0] counter;
    logic [15:0] period;
    logic [7:0]  header;
    logic [15:0] offset;
    logic [7:0]  length;
  } job_slot_t;

  typedef struct packed {
    logic        kind;
    logic        success;
    logic [2:0]  slot;
    logic [7:0]  header;
    logic [15:0] offset;
    logic [7:0]  length;
    logic        last;
  } report_t;

  class job_table_tracker;
    job_slot_t jobs[SLOTS];
    report_t   pending_reports[$];
    int        mismatch_count;

    function new();
      mismatch_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
        jobs[i] = '0;
      end
    endfunction

    // advance the job table by one accepted command and queue the reports it causes
    function void note_command(input logic [1:0] cmd, input logic [7:0] hdr,
                               input logic [15:0] off, input logic [7:0] len,
                               input logic [15:0] per);
      report_t found[MAX_RESULTS];
      report_t r;
      int      n;
      int      hit;
      logic    done;
      n    = 0;
      hit  = 0;
      done = 1'b0;
      case (cmd)
        CMD_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (jobs[i].en) begin
              if (jobs[i].counter != 16'hFFFF) begin
                jobs[i].counter = jobs[i].counter + 16'd1;
              end
              if (jobs[i].counter >= jobs[i].period && n < MAX_RESULTS) begin
                jobs[i].counter = '0;
                r         = '0;
                r.kind    = KIND_DUE;
                r.slot    = i[2:0];
                r.header  = jobs[i].header;
                r.offset  = jobs[i].offset;
                r.length  = jobs[i].length;
                found[n]  = r;
                n++;
              end
            end
          end
          for (int k = 0; k < n; k++) begin
            r      = found[k];
            r.last = (k == n - 1);
            pending_reports.push_back(r);
          end
        end
        CMD_MODIFY: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!done && jobs[i].en && jobs[i].header == hdr &&
                jobs[i].offset == off && jobs[i].length == len) begin
              if (per == 16'd0) begin
                jobs[i].en = 1'b0;
              end else begin
                jobs[i].period = per;
              end
              done = 1'b1;
              hit  = i;
            end
          end
          if (!done && per != 16'd0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!done && !jobs[i].en) begin
                jobs[i] = '{en: 1'b1, counter: 16'd0, period: per, header: hdr,
                            offset: off, length: len};
                done = 1'b1;
                hit  = i;
              end
            end
          end
          r         = '0;
          r.kind    = KIND_ACK;
          r.success = done;
          r.slot    = done ? hit[2:0] : 3'd0;
          r.last    = 1'b1;
          pending_reports.push_back(r);
        end
        CMD_STOP: begin
          for (int i = 0; i < SLOTS; i++) begin
            jobs[i].en = 1'b0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    // compare one accepted report with the oldest one outstanding
    function void check_report(input report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual kind %0d slot %0d",
                 $time, got.kind, got.slot);
        mismatch_count++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("success", want.success, got.success);
      compare_field("slot", want.slot, got.slot);
      compare_field("header", want.header, got.header);
      compare_field("offset", want.offset, got.offset);
      compare_field("length", want.length, got.length);
      compare_field("last", want.last, got.last);
    endfunction

    function int error_total();
      foreach (pending_reports[i]) begin
        $display("%0t: missing report: expected kind %0d slot %0d, actual none",
                 $time, pending_reports[i].kind, pending_reports[i].slot);
      end
      return mismatch_count + pending_reports.size();
    endfunction
  endclass

endpackage

// ----- dv/testbench.sv -----
// top-level testbench of the periodic report scheduler core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prs_pkg::*;
  import prs_tb_pkg::*;

  // command code with no meaning, ignored by the block
  localparam logic [1:0] CMD_NONE = 2'd3;

  // all dut inputs start at known values
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [1:0]  in_command     = CMD_TICK;
  logic [7:0]  in_job_header  = '0;
  logic [15:0] in_job_offset  = '0;
  logic [7:0]  in_job_length  = '0;
  logic [15:0] in_job_period  = '0;
  logic        busy;
  logic        out_valid;
  logic        out_kind;
  logic        out_success;
  logic [2:0]  out_slot;
  logic [7:0]  out_due_header;
  logic [15:0] out_due_offset;
  logic [7:0]  out_due_length;
  logic        out_last;

  job_table_tracker tracker = new();
  report_t          seen_report;

  // sender idle percentage per phase; the receiver cannot stall, so the
  // phases that would only stall it run without idling
  int idle_pct[4] = '{0, 83, 0, 24};

  periodic_report_scheduler_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_job_header  (in_job_header),
    .in_job_offset  (in_job_offset),
    .in_job_length  (in_job_length),
    .in_job_period  (in_job_period),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_success    (out_success),
    .out_slot       (out_slot),
    .out_due_header (out_due_header),
    .out_due_offset (out_due_offset),
    .out_due_length (out_due_length),
    .out_last       (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result monitor: outputs are sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_report = {out_kind, out_success, out_slot, out_due_header,
                     out_due_offset, out_due_length, out_last};
      tracker.check_report(seen_report);
    end
  end

  // present one transaction and hold it until the edge that accepts it;
  // start stays high afterwards so back-to-back transactions need no gap
  task automatic issue(input logic [1:0] cmd, input logic [7:0] hdr,
                       input logic [15:0] off, input logic [7:0] len,
                       input logic [15:0] per);
    start         <= 1'b1;
    in_command    <= cmd;
    in_job_header <= hdr;
    in_job_offset <= off;
    in_job_length <= len;
    in_job_period <= per;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    tracker.note_command(cmd, hdr, off, len, per);
  endtask

  // random sender gap, cycle by cycle, so gaps land on every phase of a walk
  task automatic hold_off(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sender waits until every outstanding report has arrived
  task automatic drain_reports();
    start <= 1'b0;
    while (tracker.pending_reports.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 16'($urandom_range(6, 1));
    end else if (r < 80) begin
      return 16'($urandom_range(20, 7));
    end
    return 16'($urandom_range(65535));
  endfunction

  // mostly well-formed job traffic: ticks against a live table, modifies that
  // hit, nearly hit or miss existing jobs, with the odd stop or unused command
  task automatic random_transaction();
    int          r;
    int          live[$];
    int          idx;
    logic [7:0]  hdr;
    logic [15:0] off;
    logic [7:0]  len;
    logic [15:0] per;
    r   = $urandom_range(99);
    hdr = 8'($urandom_range(255));
    off = 16'($urandom_range(65535));
    len = 8'($urandom_range(255));
    per = pick_period();
    for (int i = 0; i < SLOTS; i++) begin
      if (tracker.jobs[i].en) begin
        live.push_back(i);
      end
    end
    if (r < 52) begin
      issue(CMD_TICK, hdr, off, len, per);
    end else if (r < 94) begin
      if (live.size() != 0 && $urandom_range(99) < 55) begin
        idx = live[$urandom_range(live.size() - 1)];
        hdr = tracker.jobs[idx].header;
        off = tracker.jobs[idx].offset;
        len = tracker.jobs[idx].length;
        // sometimes a near miss: one key field differs by a single bit, else an exact hit
        case ($urandom_range(9))
          0: hdr ^= 8'(1 << $urandom_range(7));
          1: off ^= 16'(1 << $urandom_range(15));
          2: len ^= 8'(1 << $urandom_range(7));
          default: begin
          end
        endcase
        if ($urandom_range(99) < 25) begin
          per = '0;
        end
      end else if ($urandom_range(99) < 10) begin
        per = '0;
      end
      issue(CMD_MODIFY, hdr, off, len, per);
    end else if (r < 97) begin
      issue(CMD_STOP, hdr, off, len, per);
    end else begin
      issue(CMD_NONE, hdr, off, len, per);
    end
  endtask

  initial begin
    // synchronous reset held at the start, never again
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: empty table tick, failed delete, extreme keys and periods
    issue(CMD_TICK,   8'h00, 16'h0000, 8'h00, 16'h0000);
    issue(CMD_MODIFY, 8'h11, 16'h2222, 8'h33, 16'h0000);
    issue(CMD_MODIFY, 8'hFF, 16'hFFFF, 8'hFF, 16'h0001);
    issue(CMD_MODIFY, 8'h00, 16'h0000, 8'h00, 16'h0002);
    issue(CMD_MODIFY, 8'hA5, 16'h5A5A, 8'h3C, 16'hFFFF);
    issue(CMD_TICK,   8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    issue(CMD_TICK,   8'h00, 16'h0000, 8'h00, 16'h0000);
    // update keeps the counter, new period only
    issue(CMD_MODIFY, 8'h00, 16'h0000, 8'h00, 16'h0001);
    // same header and offset, different length: a new job, not a match
    issue(CMD_MODIFY, 8'h00, 16'h0000, 8'h01, 16'h0003);
    issue(CMD_MODIFY, 8'h5A, 16'hA5A5, 8'hC3, 16'h0001);
    issue(CMD_MODIFY, 8'h5B, 16'h1234, 8'h80, 16'h0001);
    issue(CMD_MODIFY, 8'h80, 16'h8000, 8'h7F, 16'h0001);
    issue(CMD_MODIFY, 8'h7F, 16'h7FFF, 8'h01, 16'h0001);
    // table full: the add fails
    issue(CMD_MODIFY, 8'h01, 16'h0001, 8'h02, 16'h0004);
    issue(CMD_TICK,   8'h00, 16'h0000, 8'h00, 16'h0000);
    // delete slot 0, then the next add lands in the lowest free slot
    issue(CMD_MODIFY, 8'hFF, 16'hFFFF, 8'hFF, 16'h0000);
    issue(CMD_MODIFY, 8'hC0, 16'h0F0F, 8'hF0, 16'h0001);
    // unused command changes nothing
    issue(CMD_NONE,   8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    // every slot due on the same tick
    issue(CMD_MODIFY, 8'h00, 16'h0000, 8'h01, 16'h0001);
    issue(CMD_MODIFY, 8'hA5, 16'h5A5A, 8'h3C, 16'h0001);
    issue(CMD_TICK,   8'h00, 16'h0000, 8'h00, 16'h0000);
    issue(CMD_TICK,   8'h00, 16'h0000, 8'h00, 16'h0000);
    // stop, then nothing is due and nothing matches
    issue(CMD_STOP,   8'h00, 16'h0000, 8'h00, 16'h0000);
    issue(CMD_TICK,   8'h00, 16'h0000, 8'h00, 16'h0000);
    issue(CMD_MODIFY, 8'hC0, 16'h0F0F, 8'hF0, 16'h0000);

    // random part in idling phases; the sender drains the pipe between some
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 102; k++) begin
        hold_off(idle_pct[p]);
        random_transaction();
      end
      if (p == 0 || p == 2) begin
        drain_reports();
      end
    end

    // wait for the last reports, then for a walk that may still be running
    drain_reports();
    repeat (20) @(posedge clk);
    if (tracker.error_total() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/prs_pkg.sv
rtl/prs_ram.sv
rtl/periodic_report_scheduler_core.sv
dv/prs_tb_pkg.sv
dv/testbench.sv
